>>> hdl/sird_pkg.sv
// sird_pkg: shared types, constants and helpers for the signed integer to
// radix digits converter. No dependencies.
package sird_pkg;

  localparam int VALUE_WIDTH      = 32;
  localparam int RADIX_WIDTH      = 6;
  localparam int DIGIT_WIDTH      = 6;
  localparam int CHAR_WIDTH       = 7;
  localparam int MAX_DIGITS_DEF   = 32;

  // Long division handles this many dividend bits per cycle.
  localparam int CHUNK_BITS = 8;
  localparam int DIV_STEPS  = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int DIV_WIDTH  = DIV_STEPS * CHUNK_BITS;
  localparam int STEP_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = RADIX_WIDTH'(2);
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = RADIX_WIDTH'(36);

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_A     = 7'h41;
  localparam logic [CHAR_WIDTH-1:0] CHAR_Z     = 7'h5A;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 7'h39;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'h2D;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic        [RADIX_WIDTH-1:0] radix;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] character;
    logic                  last;
  } out_item_t;

  // Classified job handed from front to back.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] mag;
    logic [RADIX_WIDTH-1:0] radix;
    logic                   neg;
  } job_t;

  // Queue to back-end handshake.
  typedef struct packed {
    logic valid;
    job_t job;
  } job_slot_t;

  function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] c;
    if (d < DIGIT_WIDTH'(10)) begin
      c = CHAR_ZERO + CHAR_WIDTH'(d);
    end else begin
      c = CHAR_A + CHAR_WIDTH'(d - DIGIT_WIDTH'(10));
    end
    return c;
  endfunction

endpackage

>>> hdl/sird_front.sv
// sird_front: sign split, magnitude and radix clamp of an incoming item.
// Depends on sird_pkg.
module sird_front import sird_pkg::*; (
  input  in_item_t request,
  output job_t     job
);

  logic neg;

  assign neg = request.value[VALUE_WIDTH-1];

  always_comb begin
    job.neg = neg;
    // Two's complement negate; the most negative value comes out as its
    // unsigned magnitude.
    job.mag = neg ? (~request.value + VALUE_WIDTH'(1)) : request.value;
    if (request.radix < RADIX_MIN) begin
      job.radix = RADIX_MIN;
    end else if (request.radix > RADIX_MAX) begin
      job.radix = RADIX_MAX;
    end else begin
      job.radix = request.radix;
    end
  end

endmodule

>>> hdl/sird_queue.sv
// sird_queue: two-entry job queue between front and back.
// Depends on sird_pkg.
module sird_queue import sird_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  output logic      full,
  input  logic      pop,
  output job_slot_t head
);

  job_t        slots [2];
  logic        wp;
  logic        rp;
  logic [1:0]  cnt;
  logic        do_push;
  logic        do_pop;

  assign full     = (cnt == 2'd2);
  assign do_push  = push && !full;
  assign do_pop   = pop && (cnt != 2'd0);
  assign head.valid = (cnt != 2'd0);
  assign head.job   = slots[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> hdl/sird_back.sv
// sird_back: iterative long division into the digit store, then character
// emission most significant first. Depends on sird_pkg.
module sird_back import sird_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  job_slot_t head,
  output logic      pop,
  output logic      strobe,
  output out_item_t result
);

  localparam int IDX_W = $clog2(MAX_DIGITS);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SIGN, S_EMIT} state_t;

  state_t                 state;
  logic [DIV_WIDTH-1:0]   quo;
  logic [DIGIT_WIDTH-1:0] rem;
  logic [RADIX_WIDTH-1:0] radix;
  logic                   neg;
  logic [STEP_W-1:0]      step;
  logic [IDX_W-1:0]       idx;

  logic [DIGIT_WIDTH-1:0] digit_store [MAX_DIGITS];
  logic [DIGIT_WIDTH-1:0] rd_data;
  logic                   rd_valid;
  logic                   rd_last;

  logic [DIV_WIDTH-1:0]   quo_next;
  logic [DIGIT_WIDTH-1:0] rem_next;
  logic                   digit_done;
  logic                   wr_en;

  // One chunk of restoring division; remainder stays below radix.
  always_comb begin
    logic [DIGIT_WIDTH:0]   t;
    logic [DIGIT_WIDTH-1:0] r;
    logic [CHUNK_BITS-1:0]  q;
    r = rem;
    q = '0;
    for (int k = 0; k < CHUNK_BITS; k++) begin
      t = {r, quo[DIV_WIDTH-1-k]};
      if (t >= {1'b0, radix}) begin
        t    = t - {1'b0, radix};
        q[CHUNK_BITS-1-k] = 1'b1;
      end
      r = t[DIGIT_WIDTH-1:0];
    end
    rem_next = r;
    if (DIV_WIDTH > CHUNK_BITS) begin
      quo_next = {quo[DIV_WIDTH-CHUNK_BITS-1:0], q};
    end else begin
      quo_next = DIV_WIDTH'(q);
    end
  end

  assign digit_done = (state == S_DIV) && (step == STEP_W'(DIV_STEPS - 1));
  assign wr_en      = digit_done;
  assign pop        = (state == S_IDLE) && head.valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_store[idx] <= rem_next;
    end
    if (state == S_EMIT) begin
      rd_data <= digit_store[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      idx      <= '0;
      neg      <= 1'b0;
      rd_valid <= 1'b0;
      rd_last  <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      rd_valid <= 1'b0;
      strobe   <= 1'b0;
      if (rd_valid) begin
        strobe           <= 1'b1;
        result.character <= digit_char(rd_data);
        result.last      <= rd_last;
      end
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            quo   <= DIV_WIDTH'(head.job.mag);
            radix <= head.job.radix;
            neg   <= head.job.neg;
            rem   <= '0;
            step  <= '0;
            idx   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (digit_done) begin
            step <= '0;
            rem  <= '0;
            quo  <= quo_next;
            if ((quo_next != '0) && (idx != IDX_W'(MAX_DIGITS - 1))) begin
              idx <= idx + IDX_W'(1);
            end else begin
              state <= neg ? S_SIGN : S_EMIT;
            end
          end else begin
            step <= step + STEP_W'(1);
            rem  <= rem_next;
            quo  <= quo_next;
          end
        end
        S_SIGN: begin
          strobe           <= 1'b1;
          result.character <= CHAR_MINUS;
          result.last      <= 1'b0;
          state            <= S_EMIT;
        end
        S_EMIT: begin
          rd_valid <= 1'b1;
          rd_last  <= (idx == '0);
          if (idx == '0) begin
            state <= S_IDLE;
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/signed_int_to_radix_digits.sv
// signed_int_to_radix_digits: top level of the integer to radix text converter.
// Depends on sird_pkg, sird_front, sird_queue, sird_back.
//
// Usage:
//   Input: drive request (value, radix) and raise start; the item is taken at
//   a rising edge with start high and busy low. busy means the two-entry job
//   queue is full. Radix is clamped to 2..36; zero gives a single '0'.
//   Output: one ASCII character per strobe cycle, most significant first, a
//   leading '-' for negative values; result.last marks the final character.
//   The receiver cannot hold results off, so strobe is never stalled.
// Per item (DIV_STEPS = 4 for 32-bit values): the long divider runs DIV_STEPS
//   chunk steps per digit, a leading '-' is emitted if negative, then one character
//   per cycle comes from the digit store through the read register and the
//   output register. The back end works on one item at a time; the queue takes
//   new items meanwhile.
// Reset: synchronous, clears the queue, back-end state and strobe. The digit
//   store needs no clearing since every digit is written before it is read.
module signed_int_to_radix_digits import sird_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  request,
  output logic      strobe,
  output out_item_t result
);

  job_t      front_job;
  job_slot_t head;
  logic      pop;

  // Front: sign/magnitude split and radix clamp.
  sird_front u_front (
    .request (request),
    .job     (front_job)
  );

  // Decoupling queue; its full flag is the busy handshake.
  sird_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (start),
    .push_job (front_job),
    .full     (busy),
    .pop      (pop),
    .head     (head)
  );

  // Back: divider, digit store and character emitter.
  sird_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

endmodule

>>> hdl/sird_checker.sv
// sird_checker: port-level assertions for signed_int_to_radix_digits, with
// its bind. Depends on sird_pkg.
module sird_checker import sird_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      strobe,
  input out_item_t result
);

  // A sign is always followed by at least one digit.
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (result.character == CHAR_MINUS)) |-> !result.last)
    else $error("minus sign marked last");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ((result.character == CHAR_MINUS) ||
                ((result.character >= CHAR_ZERO) && (result.character <= CHAR_NINE)) ||
                ((result.character >= CHAR_A) && (result.character <= CHAR_Z))))
    else $error("illegal character");

  // The queue only fills up on an offered item.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  a_reset_strobe: assert property (@(posedge clk) rst |=> !strobe)
    else $error("strobe after reset");

  a_reset_busy: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy after reset");

endmodule

bind signed_int_to_radix_digits sird_checker u_sird_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .strobe  (strobe),
  .result  (result)
);
